>>> rtl/core/alt_pkg.sv
`default_nettype none
package alt_pkg;

	// Table geometry and field widths.
	localparam int RECORDS = 64;
	localparam int IDX_W   = (RECORDS > 1) ? $clog2(RECORDS) : 1;
	localparam int CNT_W   = $clog2(RECORDS + 1);
	localparam int ADDR_W  = 48;
	localparam int SIZE_W  = 48;
	localparam int ESIZE_W = 32;
	localparam int ECNT_W  = 16;
	localparam int REC_W   = ADDR_W + SIZE_W;

	// Input command codes.
	typedef enum logic [1:0] {
		CMD_ALLOC  = 2'd0,
		CMD_FREE   = 2'd1,
		CMD_RESIZE = 2'd2,
		CMD_REPORT = 2'd3
	} cmd_t;

	// Result status codes.
	typedef enum logic [1:0] {
		STS_DONE      = 2'd0,
		STS_FULL      = 2'd1,
		STS_NOT_FOUND = 2'd2,
		STS_NOTHING   = 2'd3
	} status_t;

	// Operation that an accepted item turns into.
	typedef enum logic [2:0] {
		OP_NOP,
		OP_ALLOC,
		OP_FREE,
		OP_MOVE,
		OP_REPORT
	} op_t;

	// Controller states.
	typedef enum logic [2:0] {
		S_IDLE,
		S_ALLOC,
		S_SCAN,
		S_REPLY,
		S_FLUSH
	} state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load;
		logic alloc;
		logic scan;
		logic reply;
		logic flush;
	} dp_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		op_t  op_in;
		op_t  op;
		logic hit;
		logic scan_done;
	} dp_sts_t;

	// Map a command and its operands onto the operation to perform.
	function automatic op_t decode_op(cmd_t cmd, logic [ADDR_W-1:0] old_addr,
			logic [ESIZE_W-1:0] esize);
		op_t op;
		logic old_null;
		logic size_zero;
		old_null  = (old_addr == '0);
		size_zero = (esize == '0);
		case (cmd)
			CMD_ALLOC: begin
				op = OP_ALLOC;
			end
			CMD_FREE: begin
				op = old_null ? OP_NOP : OP_FREE;
			end
			CMD_RESIZE: begin
				if (old_null && size_zero) begin
					op = OP_NOP;
				end else if (old_null) begin
					op = OP_ALLOC;
				end else if (size_zero) begin
					op = OP_FREE;
				end else begin
					op = OP_MOVE;
				end
			end
			CMD_REPORT: begin
				op = OP_REPORT;
			end
			default: begin
				op = OP_NOP;
			end
		endcase
		return op;
	endfunction

endpackage
`default_nettype wire

>>> rtl/core/alt_ram.sv
`default_nettype none
module alt_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	clk,
	wr_en,
	wr_addr,
	wr_data,
	rd_en,
	rd_addr,
	rd_data
);
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	input  wire logic             clk;
	input  wire logic             wr_en;
	input  wire logic [AW-1:0]    wr_addr;
	input  wire logic [WIDTH-1:0] wr_data;
	input  wire logic             rd_en;
	input  wire logic [AW-1:0]    rd_addr;
	output      logic [WIDTH-1:0] rd_data;

	logic [WIDTH-1:0] mem [DEPTH];

	// One write port and one registered read port.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule
`default_nettype wire

>>> rtl/core/alt_ctrl.sv
`default_nettype none
module alt_ctrl (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             start,
	output      logic             busy,
	output      alt_pkg::dp_cmd_t dp_cmd,
	input  wire alt_pkg::dp_sts_t dp_sts
);
	import alt_pkg::*;

	state_t state_q;
	state_t state_next;

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_next;
		end
	end

	// Next state and datapath commands.
	always_comb begin
		state_next = state_q;
		dp_cmd     = '0;
		case (state_q)
			S_IDLE: begin
				if (start) begin
					dp_cmd.load = 1'b1;
					case (dp_sts.op_in)
						OP_ALLOC:  state_next = S_ALLOC;
						OP_FREE:   state_next = S_SCAN;
						OP_MOVE:   state_next = S_SCAN;
						OP_REPORT: state_next = S_SCAN;
						default:   state_next = S_REPLY;
					endcase
				end
			end
			S_ALLOC: begin
				dp_cmd.alloc = 1'b1;
				state_next   = S_REPLY;
			end
			S_SCAN: begin
				dp_cmd.scan = 1'b1;
				if (dp_sts.hit) begin
					state_next = S_REPLY;
				end else if (dp_sts.scan_done) begin
					state_next = (dp_sts.op == OP_REPORT) ? S_FLUSH : S_REPLY;
				end
			end
			S_REPLY: begin
				dp_cmd.reply = 1'b1;
				state_next   = S_IDLE;
			end
			S_FLUSH: begin
				dp_cmd.flush = 1'b1;
				state_next   = S_IDLE;
			end
			default: begin
				state_next = S_IDLE;
			end
		endcase
	end

	assign busy = (state_q != S_IDLE);

endmodule
`default_nettype wire

>>> rtl/core/alt_dp.sv
`default_nettype none
module alt_dp (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire alt_pkg::dp_cmd_t              dp_cmd,
	output      alt_pkg::dp_sts_t              dp_sts,
	input  wire alt_pkg::cmd_t                 command,
	input  wire logic [alt_pkg::ADDR_W-1:0]    old_address,
	input  wire logic [alt_pkg::ADDR_W-1:0]    new_address,
	input  wire logic [alt_pkg::ESIZE_W-1:0]   element_size,
	input  wire logic [alt_pkg::ECNT_W-1:0]    element_count,
	output      logic                          strobe,
	output      alt_pkg::status_t              status,
	output      logic                          leak_valid,
	output      logic [alt_pkg::ADDR_W-1:0]    leak_address,
	output      logic [alt_pkg::SIZE_W-1:0]    leak_size,
	output      logic                          invalid_free_seen,
	output      logic                          table_full_seen,
	output      logic                          last
);
	import alt_pkg::*;

	// Control state.
	logic [CNT_W-1:0]   count_q;
	logic [RECORDS-1:0] freed_q;
	logic               invalid_q;
	logic               full_q;
	logic [CNT_W-1:0]   idx_q;
	logic               rvalid_s1;
	logic               pend_q;
	logic               strobe_q;

	// Item and result payload.
	op_t               op_q;
	logic [ADDR_W-1:0] old_q;
	logic [ADDR_W-1:0] new_q;
	logic [SIZE_W-1:0] size_q;
	status_t           res_status_q;
	logic [IDX_W-1:0]  ridx_s1;
	logic [ADDR_W-1:0] pend_addr_q;
	logic [SIZE_W-1:0] pend_size_q;
	status_t           out_status_q;
	logic              out_valid_q;
	logic [ADDR_W-1:0] out_addr_q;
	logic [SIZE_W-1:0] out_size_q;
	logic              out_last_q;

	// Record memory interface.
	logic              wr_en;
	logic [IDX_W-1:0]  wr_addr;
	logic [REC_W-1:0]  wr_data;
	logic [REC_W-1:0]  rd_data;
	logic [ADDR_W-1:0] ent_addr;
	logic [SIZE_W-1:0] ent_size;

	// Decoded conditions.
	op_t                       op_in;
	logic [ESIZE_W+ECNT_W-1:0] product;
	logic                      table_full;
	logic                      issue;
	logic                      scan_done;
	logic                      live;
	logic                      searching;
	logic                      hit;
	logic                      report_live;

	assign op_in   = decode_op(command, old_address, element_size);
	assign product = element_size * element_count;

	assign table_full  = (count_q == CNT_W'(RECORDS));
	assign issue       = dp_cmd.scan && (idx_q < count_q);
	assign scan_done   = !rvalid_s1 && (idx_q >= count_q);
	assign ent_addr    = rd_data[REC_W-1 -: ADDR_W];
	assign ent_size    = rd_data[SIZE_W-1:0];
	assign live        = rvalid_s1 && !freed_q[ridx_s1];
	assign searching   = (op_q == OP_FREE) || (op_q == OP_MOVE);
	assign hit         = dp_cmd.scan && searching && live && (ent_addr == old_q);
	assign report_live = dp_cmd.scan && (op_q == OP_REPORT) && live;

	// A move rewrites the matching record; an allocation fills the next unused one.
	always_comb begin
		wr_en   = 1'b0;
		wr_addr = count_q[IDX_W-1:0];
		wr_data = {new_q, size_q};
		if (hit && (op_q == OP_MOVE)) begin
			wr_en   = 1'b1;
			wr_addr = ridx_s1;
		end else if (dp_cmd.alloc && !table_full) begin
			wr_en = 1'b1;
		end
	end

	alt_ram #(
		.WIDTH(REC_W),
		.DEPTH(RECORDS)
	) u_ram (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_en   (issue),
		.rd_addr (idx_q[IDX_W-1:0]),
		.rd_data (rd_data)
	);

	// Control registers: fill count, freed bits, flags and scan pipeline.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q   <= '0;
			freed_q   <= '0;
			invalid_q <= 1'b0;
			full_q    <= 1'b0;
			idx_q     <= '0;
			rvalid_s1 <= 1'b0;
			pend_q    <= 1'b0;
			strobe_q  <= 1'b0;
		end else begin
			if (dp_cmd.load) begin
				idx_q     <= '0;
				rvalid_s1 <= 1'b0;
				pend_q    <= 1'b0;
			end
			if (dp_cmd.scan) begin
				rvalid_s1 <= issue;
				if (issue) begin
					idx_q <= idx_q + CNT_W'(1);
				end
			end
			if (dp_cmd.alloc) begin
				if (table_full) begin
					full_q <= 1'b1;
				end else begin
					count_q                   <= count_q + CNT_W'(1);
					freed_q[count_q[IDX_W-1:0]] <= 1'b0;
				end
			end
			if (hit && (op_q == OP_FREE)) begin
				freed_q[ridx_s1] <= 1'b1;
			end
			if (dp_cmd.scan && searching && scan_done) begin
				invalid_q <= 1'b1;
			end
			if (report_live) begin
				pend_q <= 1'b1;
			end
			strobe_q <= dp_cmd.reply || dp_cmd.flush || (report_live && pend_q);
		end
	end

	// Payload registers: operands, item status and result fields.
	always_ff @(posedge clk) begin
		if (dp_cmd.load) begin
			op_q         <= op_in;
			old_q        <= old_address;
			new_q        <= new_address;
			size_q       <= (command == CMD_ALLOC) ? SIZE_W'(product)
				: SIZE_W'(element_size);
			res_status_q <= (op_in == OP_NOP) ? STS_NOTHING : STS_DONE;
		end
		if (issue) begin
			ridx_s1 <= idx_q[IDX_W-1:0];
		end
		if (dp_cmd.alloc && table_full) begin
			res_status_q <= STS_FULL;
		end
		if (dp_cmd.scan && searching && scan_done) begin
			res_status_q <= STS_NOT_FOUND;
		end
		// A leaking record is held back one step so the final one can carry last.
		if (report_live) begin
			pend_addr_q <= ent_addr;
			pend_size_q <= ent_size;
			if (pend_q) begin
				out_status_q <= STS_DONE;
				out_valid_q  <= 1'b1;
				out_addr_q   <= pend_addr_q;
				out_size_q   <= pend_size_q;
				out_last_q   <= 1'b0;
			end
		end
		if (dp_cmd.reply) begin
			out_status_q <= res_status_q;
			out_valid_q  <= 1'b0;
			out_addr_q   <= '0;
			out_size_q   <= '0;
			out_last_q   <= 1'b1;
		end
		if (dp_cmd.flush) begin
			out_last_q <= 1'b1;
			if (pend_q) begin
				out_status_q <= STS_DONE;
				out_valid_q  <= 1'b1;
				out_addr_q   <= pend_addr_q;
				out_size_q   <= pend_size_q;
			end else begin
				out_status_q <= STS_NOTHING;
				out_valid_q  <= 1'b0;
				out_addr_q   <= '0;
				out_size_q   <= '0;
			end
		end
	end

	// Status toward the controller.
	always_comb begin
		dp_sts.op_in     = op_in;
		dp_sts.op        = op_q;
		dp_sts.hit       = hit;
		dp_sts.scan_done = scan_done;
	end

	assign strobe            = strobe_q;
	assign status            = out_status_q;
	assign leak_valid        = out_valid_q;
	assign leak_address      = out_addr_q;
	assign leak_size         = out_size_q;
	assign last              = out_last_q;
	assign invalid_free_seen = invalid_q;
	assign table_full_seen   = full_q;

endmodule
`default_nettype wire

>>> rtl/core/allocation_leak_tracker.sv
// An allocate or a no-op item gives its one result; a free or resize scans the filled
// records one per cycle. A report streams one result per leaking record.
// One item is handled at a time; the next transfer can be taken from the cycle that
// shows the final result of the last one.
// Reset clears the record count, the freed bits and both sticky flags; the record memory is
// not cleared, since only filled records are ever read. Results cannot be stalled.
`default_nettype none
module allocation_leak_tracker (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          start,
	output      logic                          busy,
	input  wire alt_pkg::cmd_t                 command,
	input  wire logic [alt_pkg::ADDR_W-1:0]    old_address,
	input  wire logic [alt_pkg::ADDR_W-1:0]    new_address,
	input  wire logic [alt_pkg::ESIZE_W-1:0]   element_size,
	input  wire logic [alt_pkg::ECNT_W-1:0]    element_count,
	output      logic                          strobe,
	output      alt_pkg::status_t              status,
	output      logic                          leak_valid,
	output      logic [alt_pkg::ADDR_W-1:0]    leak_address,
	output      logic [alt_pkg::SIZE_W-1:0]    leak_size,
	output      logic                          invalid_free_seen,
	output      logic                          table_full_seen,
	output      logic                          last
);
	import alt_pkg::*;

	dp_cmd_t dp_cmd;
	dp_sts_t dp_sts;

	// Sequencer for allocation, search, report and reply steps.
	alt_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.dp_cmd (dp_cmd),
		.dp_sts (dp_sts)
	);

	// Record table, flags and result registers.
	alt_dp u_dp (
		.clk               (clk),
		.arst_n            (arst_n),
		.dp_cmd            (dp_cmd),
		.dp_sts            (dp_sts),
		.command           (command),
		.old_address       (old_address),
		.new_address       (new_address),
		.element_size      (element_size),
		.element_count     (element_count),
		.strobe            (strobe),
		.status            (status),
		.leak_valid        (leak_valid),
		.leak_address      (leak_address),
		.leak_size         (leak_size),
		.invalid_free_seen (invalid_free_seen),
		.table_full_seen   (table_full_seen),
		.last              (last)
	);

endmodule
`default_nettype wire
